FILE: rtl/hsl_pkg.sv
// Shared constants, types and helper functions for the heading slew limiter.
package hsl_pkg;

  localparam int CORDIC_STEPS = 14;
  localparam int CX_W = 35;
  localparam int CZ_W = 24;

  localparam logic signed [17:0] PI_Q12     = 18'sd12868;
  localparam logic signed [17:0] TWO_PI_Q12 = 18'sd25736;
  localparam logic signed [CZ_W-1:0] PI_Q20 = 24'sd3294199;

  localparam logic [1:0] KIND_TRACK   = 2'd0;
  localparam logic [1:0] KIND_HOLD    = 2'd1;
  localparam logic [1:0] KIND_INVALID = 2'd2;
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;

  typedef logic signed [17:0] hwide_t;

  function automatic logic [19:0] cordic_angle(input logic [4:0] idx);
    logic [19:0] a;
    case (idx)
      5'd0:    a = 20'd823550;
      5'd1:    a = 20'd486170;
      5'd2:    a = 20'd256879;
      5'd3:    a = 20'd130396;
      5'd4:    a = 20'd65451;
      5'd5:    a = 20'd32757;
      5'd6:    a = 20'd16383;
      5'd7:    a = 20'd8192;
      5'd8:    a = 20'd4096;
      5'd9:    a = 20'd2048;
      5'd10:   a = 20'd1024;
      5'd11:   a = 20'd512;
      5'd12:   a = 20'd256;
      5'd13:   a = 20'd128;
      5'd14:   a = 20'd64;
      5'd15:   a = 20'd32;
      5'd16:   a = 20'd16;
      5'd17:   a = 20'd8;
      5'd18:   a = 20'd4;
      5'd19:   a = 20'd2;
      default: a = 20'd0;
    endcase
    return a;
  endfunction

  function automatic hwide_t wrap_once(input hwide_t h);
    hwide_t r;
    if (h < -PI_Q12) r = h + TWO_PI_Q12;
    else if (h > PI_Q12) r = h - TWO_PI_Q12;
    else r = h;
    return r;
  endfunction

endpackage

FILE: rtl/hsl_mul.sv
// Shift-add multiplier, 16 by 16 bits unsigned, one multiplier bit per cycle.
module hsl_mul
  import hsl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] a,
  input  logic [15:0] b,
  output logic        done,
  output logic [31:0] p
);

  logic [31:0] a_r;
  logic [15:0] b_r;
  logic [31:0] p_r;
  logic [3:0]  cnt_r;
  logic        run_r;
  logic        done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= {16'b0, a};
      b_r <= b;
      p_r <= '0;
    end else if (run_r) begin
      if (b_r[0]) p_r <= p_r + a_r;
      a_r <= {a_r[30:0], 1'b0};
      b_r <= {1'b0, b_r[15:1]};
    end
  end

  assign done = done_r;
  assign p    = p_r;

endmodule

FILE: rtl/hsl_cordic.sv
// Vectoring CORDIC for atan2, one rotation per cycle, result in Q3.12 radians.
module hsl_cordic
  import hsl_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] x_in,
  input  logic signed [31:0] y_in,
  output logic               done,
  output logic signed [15:0] angle
);

  logic signed [CX_W-1:0] x_r, y_r, xs, ys, x0, y0;
  logic signed [CZ_W-1:0] z_r, z0, ang, zr;
  logic [4:0] cnt_r;
  logic       run_r;
  logic       done_r;
  logic signed [15:0] r;

  assign x0 = CX_W'(x_in);
  assign y0 = CX_W'(y_in);
  assign xs = x_r >>> cnt_r;
  assign ys = y_r >>> cnt_r;
  assign ang = {4'b0, cordic_angle(cnt_r)};
  assign z0 = (y_in >= 0) ? PI_Q20 : -PI_Q20;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(CORDIC_STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      if (x_in < 0) begin
        x_r <= -x0;
        y_r <= -y0;
        z_r <= z0;
      end else begin
        x_r <= x0;
        y_r <= y0;
        z_r <= '0;
      end
    end else if (run_r) begin
      if (!y_r[CX_W-1]) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + ang;
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - ang;
      end
    end
  end

  assign zr = z_r + 24'sd128;
  assign r  = zr[23:8];

  always_comb begin
    if (r > 16'sd12868) angle = 16'sd12868;
    else if (r < -16'sd12868) angle = -16'sd12868;
    else angle = r;
  end

  assign done = done_r;

endmodule

FILE: rtl/hsl_div.sv
// Restoring divider, 32 by 16 bits unsigned, one quotient bit per cycle.
module hsl_div
  import hsl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [15:0] den,
  output logic        done,
  output logic [31:0] q
);

  logic [31:0] n_r;
  logic [15:0] d_r;
  logic [15:0] rem_r;
  logic [16:0] rem_t;
  logic [16:0] rem_s;
  logic        ge;
  logic [4:0]  cnt_r;
  logic        run_r;
  logic        done_r;

  assign rem_t = {rem_r, n_r[31]};
  assign ge    = rem_t >= {1'b0, d_r};
  assign rem_s = rem_t - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= num;
      d_r   <= den;
      rem_r <= '0;
    end else if (run_r) begin
      rem_r <= ge ? rem_s[15:0] : rem_t[15:0];
      n_r   <= {n_r[30:0], ge};
    end
  end

  assign done = done_r;
  assign q    = n_r;

endmodule

FILE: rtl/heading_slew_limiter_unit.sv
// Heading slew limiter top level: sequencer, state and stream ports.
//
//   port group | dir | contents
//   in_*       | in  | tuser kind; tdata dir_x, dir_y, dir_z, elapsed_time
//   out_*      | out | tdata heading, heading_rate
//   cfg_*      | in  | register writes, index 0 max_turn_rate, 1 min_direction_length
//
// A tracking word runs five shift-add products (step limit, three squares,
// threshold square), then the CORDIC rotations and the divide; a short vector
// skips the CORDIC and a clamped rate skips the divide. Hold and invalid words
// go straight to the result stage. One word is in work at a time; the output
// register lets the next word in while a result waits. Reset is synchronous,
// active low.
module heading_slew_limiter_unit
  import hsl_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [111:0] in_tdata,   // dir_x, dir_y, dir_z, elapsed_time
  input  logic [1:0]   in_tuser,   // kind
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata,  // heading, heading_rate, zero pad
  input  logic         cfg_we,
  input  logic         cfg_addr,
  input  logic [15:0]  cfg_wdata
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MSTART = 4'd1;
  localparam logic [3:0] S_MUL    = 4'd2;
  localparam logic [3:0] S_CSTART = 4'd3;
  localparam logic [3:0] S_CORD   = 4'd4;
  localparam logic [3:0] S_DECIDE = 4'd5;
  localparam logic [3:0] S_DSTART = 4'd6;
  localparam logic [3:0] S_DIV    = 4'd7;
  localparam logic [3:0] S_AVG    = 4'd8;
  localparam logic [3:0] S_FIN    = 4'd9;

  localparam logic [2:0] MOP_STEP = 3'd0;
  localparam logic [2:0] MOP_X    = 3'd1;
  localparam logic [2:0] MOP_Y    = 3'd2;
  localparam logic [2:0] MOP_Z    = 3'd3;
  localparam logic [2:0] MOP_THR  = 3'd4;

  localparam logic CFG_MAX_RATE = 1'b0;
  localparam logic CFG_MIN_LEN  = 1'b1;

  logic [3:0]  state_r;
  logic [2:0]  mop_r;
  logic [14:0] max_rate_r;
  logic [15:0] min_len_r;
  logic signed [15:0] prev_head_r, prev_rate_r;
  logic signed [31:0] x_r, y_r, z_r;
  logic [15:0] et_r;
  logic [15:0] dmax_r;
  logic [33:0] acc_r;
  logic signed [15:0] target_r;
  hwide_t      head_r;
  logic signed [15:0] rate_r;
  logic        dneg_r;
  logic [31:0] num_r;
  logic signed [14:0] res_head_r;
  logic signed [15:0] res_rate_r;
  logic        out_valid_r;
  logic [30:0] out_data_r;

  logic [31:0] ax, ay, az;
  logic        big;
  logic [15:0] ma, mb;
  logic        mul_done, cord_done, div_done;
  logic [31:0] mul_p, div_q;
  logic signed [15:0] cord_ang;
  logic [32:0] dsum;
  logic        accept;

  hwide_t d, dm, last, rmax, head_c, rate_c, step, hsum, absd;
  logic   free_c;
  logic signed [16:0] rsum;
  logic [14:0] qsat;

  assign accept = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);

  assign ax = x_r[31] ? (~x_r + 32'd1) : x_r;
  assign ay = y_r[31] ? (~y_r + 32'd1) : y_r;
  assign az = z_r[31] ? (~z_r + 32'd1) : z_r;
  assign big = (ax[31:16] != 16'd0) || (ay[31:16] != 16'd0) || (az[31:16] != 16'd0);

  always_comb begin
    case (mop_r)
      MOP_STEP: begin ma = {1'b0, max_rate_r}; mb = et_r; end
      MOP_X:    begin ma = ax[15:0]; mb = ax[15:0]; end
      MOP_Y:    begin ma = ay[15:0]; mb = ay[15:0]; end
      MOP_Z:    begin ma = az[15:0]; mb = az[15:0]; end
      default:  begin ma = min_len_r; mb = min_len_r; end
    endcase
  end

  hsl_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(state_r == S_MSTART),
    .a(ma), .b(mb), .done(mul_done), .p(mul_p)
  );

  hsl_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .start(state_r == S_CSTART),
    .x_in(x_r), .y_in(y_r), .done(cord_done), .angle(cord_ang)
  );

  hsl_div u_div (
    .clk(clk), .rst_n(rst_n), .start(state_r == S_DSTART),
    .num(num_r), .den(et_r), .done(div_done), .q(div_q)
  );

  assign dsum = {1'b0, mul_p} + 33'd32768;
  assign last = hwide_t'(prev_head_r);
  assign dm   = {2'b0, dmax_r};
  assign rmax = {3'b0, max_rate_r};
  assign d    = hwide_t'(target_r) - last;
  assign absd = d[17] ? -d : d;

  always_comb begin
    free_c = 1'b0;
    if (d > PI_Q12) begin
      head_c = (d - TWO_PI_Q12 < -dm) ? wrap_once(wrap_once(last - dm)) : hwide_t'(target_r);
      rate_c = -rmax;
    end else if (d < -PI_Q12) begin
      head_c = (d + TWO_PI_Q12 > dm) ? wrap_once(wrap_once(last + dm)) : hwide_t'(target_r);
      rate_c = rmax;
    end else if (d < -dm) begin
      head_c = wrap_once(wrap_once(last - dm));
      rate_c = -rmax;
    end else if (d > dm) begin
      head_c = wrap_once(wrap_once(last + dm));
      rate_c = rmax;
    end else begin
      head_c = hwide_t'(target_r);
      free_c = 1'b1;
      if (d == 0) rate_c = '0;
      else rate_c = d[17] ? -rmax : rmax;
    end
  end

  assign qsat = (div_q > {17'b0, max_rate_r}) ? max_rate_r : div_q[14:0];
  assign step = (head_r - last < 0) ? last - head_r : head_r - last;
  assign hsum = (last + head_r) >>> 1;
  assign rsum = 17'(prev_rate_r) + 17'(rate_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mop_r       <= MOP_STEP;
      max_rate_r  <= 15'd12868;
      min_len_r   <= 16'd6554;
      prev_head_r <= '0;
      prev_rate_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == CFG_MAX_RATE) max_rate_r <= cfg_wdata[14:0];
        if (cfg_addr == CFG_MIN_LEN) min_len_r <= cfg_wdata;
      end
      if (state_r == S_FIN && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_tuser == KIND_TRACK) begin
              mop_r   <= MOP_STEP;
              state_r <= S_MSTART;
            end else begin
              if (in_tuser != KIND_HOLD) prev_head_r <= '0;
              state_r <= S_FIN;
            end
          end
        end
        S_MSTART: state_r <= S_MUL;
        S_MUL: begin
          if (mul_done) begin
            if (mop_r == MOP_THR) begin
              if (big || (acc_r > {2'b0, mul_p})) state_r <= S_CSTART;
              else state_r <= S_DECIDE;
            end else begin
              mop_r   <= mop_r + 3'd1;
              state_r <= S_MSTART;
            end
          end
        end
        S_CSTART: state_r <= S_CORD;
        S_CORD:   if (cord_done) state_r <= S_DECIDE;
        S_DECIDE: state_r <= (free_c && d != 0 && et_r != 16'd0) ? S_DSTART : S_AVG;
        S_DSTART: state_r <= S_DIV;
        S_DIV:    if (div_done) state_r <= S_AVG;
        S_AVG: begin
          prev_head_r <= (step <= dm) ? hsum[15:0] : head_r[15:0];
          prev_rate_r <= rsum[16:1];
          state_r     <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_r || out_tready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r    <= in_tdata[31:0];
      y_r    <= in_tdata[63:32];
      z_r    <= in_tdata[95:64];
      et_r   <= in_tdata[111:96];
      acc_r  <= '0;
      res_head_r <= (in_tuser == KIND_HOLD) ? prev_head_r[14:0] : 15'sd0;
      res_rate_r <= '0;
    end
    if (state_r == S_MUL && mul_done) begin
      case (mop_r)
        MOP_STEP: dmax_r <= dsum[31:16];
        MOP_THR:  target_r <= prev_head_r;
        default:  acc_r <= acc_r + {2'b0, mul_p};
      endcase
    end
    if (state_r == S_CORD && cord_done) target_r <= cord_ang;
    if (state_r == S_DECIDE) begin
      head_r <= head_c;
      rate_r <= rate_c[15:0];
      dneg_r <= d[17];
      num_r  <= {absd[15:0], 16'b0} + {17'b0, et_r[15:1]};
    end
    if (state_r == S_DIV && div_done) begin
      rate_r <= dneg_r ? -{1'b0, qsat} : {1'b0, qsat};
    end
    if (state_r == S_AVG) begin
      res_head_r <= (step <= dm) ? hsum[14:0] : head_r[14:0];
      res_rate_r <= rsum[16:1];
    end
    if (state_r == S_FIN && (!out_valid_r || out_tready)) begin
      out_data_r <= {res_rate_r, res_head_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_data_r};

endmodule

FILE: rtl/hsl_checker.sv
// Port-level checks for the heading slew limiter, bound to the top level.
module hsl_checker
  import hsl_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [31:0]  out_tdata
);

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("word accepted while another is in work");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[14:0]) <= 15'sd12868) &&
                   ($signed(out_tdata[14:0]) >= -15'sd12868))
    else $error("heading outside pi");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[31] == 1'b0)
    else $error("pad bit set");

endmodule

bind heading_slew_limiter_unit hsl_checker u_hsl_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
